FILE: hw/rtl/fpfa_pkg.sv
`default_nettype none
package fpfa_pkg;

   localparam int BLOCKS_DEF    = 16;
   localparam int SIZE_BITS_DEF = 16;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_REQ   = 2'd2;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;
   localparam logic [1:0] POLICY_NONE  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear_pick;
      logic cmp_en;
   } scan_ctl_type;

   typedef struct packed {
      logic idle;
      logic out_load;
   } seq_stat_type;

endpackage
`default_nettype wire

FILE: hw/rtl/fpfa_table.sv
`default_nettype none
module fpfa_table #(
   parameter int BLOCKS    = fpfa_pkg::BLOCKS_DEF,
   parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF,
   parameter int IDX_BITS  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1,
   parameter int CNT_BITS  = $clog2(BLOCKS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 clr,
   input  wire logic                 load,
   input  wire logic [SIZE_BITS-1:0] load_size,
   input  wire logic [IDX_BITS-1:0]  rd_addr,
   input  wire logic                 mark_en,
   input  wire logic [IDX_BITS-1:0]  mark_idx,
   output logic      [SIZE_BITS-1:0] rd_size,
   output logic                      rd_used,
   output logic      [CNT_BITS-1:0]  count
);

   logic [SIZE_BITS-1:0] mem [BLOCKS];
   logic [BLOCKS-1:0]    used_ff;
   logic [BLOCKS-1:0]    used_in;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic [SIZE_BITS-1:0] rd_size_ff;
   logic                 rd_used_ff;
   logic                 room;

   assign room = (count_ff < CNT_BITS'(BLOCKS));

   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      if (clr) begin
         used_in  = '0;
         count_in = '0;
      end else if (load && room) begin
         used_in[count_ff[IDX_BITS-1:0]] = 1'b0;
         count_in = count_ff + CNT_BITS'(1);
      end else if (mark_en) begin
         used_in[mark_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !clr && room) begin
         mem[count_ff[IDX_BITS-1:0]] <= load_size;
      end
      rd_size_ff <= mem[rd_addr];
      rd_used_ff <= used_ff[rd_addr];
   end

   assign rd_size = rd_size_ff;
   assign rd_used = rd_used_ff;
   assign count   = count_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fpfa_fit.sv
`default_nettype none
module fpfa_fit #(
   parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF,
   parameter int IDX_BITS  = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fpfa_pkg::scan_ctl_type ctl,
   input  wire logic [IDX_BITS-1:0]   cmp_idx,
   input  wire logic [SIZE_BITS-1:0]  cand_size,
   input  wire logic                  cand_used,
   input  wire logic [SIZE_BITS-1:0]  need,
   input  wire logic [1:0]            policy,
   output logic                       granted,
   output logic      [SIZE_BITS-1:0]  pick_size,
   output logic      [IDX_BITS-1:0]   pick_idx
);

   logic                 found_ff;
   logic                 found_in;
   logic [SIZE_BITS-1:0] pick_size_ff;
   logic [SIZE_BITS-1:0] pick_size_in;
   logic [IDX_BITS-1:0]  pick_idx_ff;
   logic [IDX_BITS-1:0]  pick_idx_in;
   logic                 fits;
   logic                 take;

   assign fits = (cand_size >= need);

   always_comb begin
      case (policy)
         fpfa_pkg::POLICY_FIRST: take = fits && !found_ff;
         fpfa_pkg::POLICY_BEST:  take = fits && (!found_ff || cand_size < pick_size_ff);
         fpfa_pkg::POLICY_WORST: take = !found_ff || cand_size > pick_size_ff;
         default:                take = 1'b0;
      endcase
   end

   always_comb begin
      found_in     = found_ff;
      pick_size_in = pick_size_ff;
      pick_idx_in  = pick_idx_ff;
      if (ctl.clear_pick) begin
         found_in = 1'b0;
      end else if (ctl.cmp_en && !cand_used && take) begin
         found_in     = 1'b1;
         pick_size_in = cand_size;
         pick_idx_in  = cmp_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pick_size_ff <= pick_size_in;
      pick_idx_ff  <= pick_idx_in;
   end

   assign granted   = found_ff && ((policy != fpfa_pkg::POLICY_WORST) || (pick_size_ff >= need));
   assign pick_size = pick_size_ff;
   assign pick_idx  = pick_idx_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fpfa_seq.sv
`default_nettype none
module fpfa_seq #(
   parameter int IDX_BITS = 4,
   parameter int CNT_BITS = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [CNT_BITS-1:0]    count,
   input  wire logic                   out_busy,
   output logic      [IDX_BITS-1:0]    rd_addr,
   output logic      [IDX_BITS-1:0]    cmp_idx,
   output fpfa_pkg::scan_ctl_type      ctl,
   output fpfa_pkg::seq_stat_type      stat
);

   fpfa_pkg::state_type state_ff;
   fpfa_pkg::state_type state_in;
   logic [IDX_BITS-1:0] idx_ff;
   logic [IDX_BITS-1:0] idx_in;
   logic [IDX_BITS-1:0] cmp_idx_ff;
   logic                cmp_en_ff;
   logic                issue;
   logic                last;

   assign last = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == count);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpfa_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (count == '0) ? fpfa_pkg::ST_RESP : fpfa_pkg::ST_SCAN;
            end
         end
         fpfa_pkg::ST_SCAN: begin
            if (last) begin
               state_in = fpfa_pkg::ST_DRAIN;
            end
         end
         fpfa_pkg::ST_DRAIN: state_in = fpfa_pkg::ST_RESP;
         fpfa_pkg::ST_RESP: begin
            if (!out_busy) begin
               state_in = fpfa_pkg::ST_IDLE;
            end
         end
         default: state_in = fpfa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      issue          = 1'b0;
      idx_in         = idx_ff;
      ctl.clear_pick = 1'b0;
      ctl.cmp_en     = cmp_en_ff;
      stat.idle      = 1'b0;
      stat.out_load  = 1'b0;
      case (state_ff)
         fpfa_pkg::ST_IDLE: begin
            stat.idle      = 1'b1;
            ctl.clear_pick = start;
            idx_in         = '0;
         end
         fpfa_pkg::ST_SCAN: begin
            issue  = 1'b1;
            idx_in = idx_ff + IDX_BITS'(1);
         end
         fpfa_pkg::ST_DRAIN: begin
         end
         fpfa_pkg::ST_RESP: begin
            stat.out_load = !out_busy;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fpfa_pkg::ST_IDLE;
         cmp_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cmp_en_ff <= issue;
      end
      idx_ff     <= idx_in;
      cmp_idx_ff <= idx_ff;
   end

   assign rd_addr    = idx_ff;
   assign cmp_idx    = cmp_idx_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/fixed_partition_fit_allocator_top.sv
// Clear and load words leave the block idle, so it stays ready for the next word.
// A request word scans the loaded entries one per cycle through a single compare
// unit fed by the size memory's registered read port, one request at a time.
// Reset (synchronous, active high) empties the table, clears all used marks,
// sets the fit policy to first fit and drops any pending result word.
`default_nettype none
module fixed_partition_fit_allocator_top #(
   parameter int BLOCKS    = fpfa_pkg::BLOCKS_DEF,
   parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF,
   parameter int IDX_BITS  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_wr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_mode,
   input  wire logic [SIZE_BITS-1:0] req_size,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_granted,
   output logic      [SIZE_BITS-1:0] rsp_granted_size,
   output logic      [IDX_BITS-1:0]  rsp_block_index
);

   localparam int CNT_BITS = $clog2(BLOCKS + 1);

   logic                   policy_ff;
   logic [1:0]             policy_q_ff;
   logic [SIZE_BITS-1:0]   need_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_granted_ff;
   logic [SIZE_BITS-1:0]   rsp_size_ff;
   logic [IDX_BITS-1:0]    rsp_idx_ff;
   logic                   req_fire;
   logic                   start;
   logic                   out_busy;
   logic [IDX_BITS-1:0]    rd_addr;
   logic [IDX_BITS-1:0]    cmp_idx;
   logic [SIZE_BITS-1:0]   cand_size;
   logic                   cand_used;
   logic [CNT_BITS-1:0]    count;
   logic                   granted;
   logic [SIZE_BITS-1:0]   pick_size;
   logic [IDX_BITS-1:0]    pick_idx;
   fpfa_pkg::scan_ctl_type ctl;
   fpfa_pkg::seq_stat_type stat;

   assign req_ready = stat.idle;
   assign req_fire  = req_valid && req_ready;
   assign start     = req_fire && (req_mode == fpfa_pkg::MODE_REQ);
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= 1'b0;
         policy_q_ff  <= fpfa_pkg::POLICY_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            policy_ff   <= 1'b1;
            policy_q_ff <= csr_wr_data;
         end
         if (stat.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (start) begin
         need_ff <= req_size;
      end
      if (stat.out_load) begin
         rsp_granted_ff <= granted;
         rsp_size_ff    <= granted ? pick_size : '0;
         rsp_idx_ff     <= granted ? pick_idx : '0;
      end
   end

   fpfa_table #(
      .BLOCKS    (BLOCKS),
      .SIZE_BITS (SIZE_BITS),
      .IDX_BITS  (IDX_BITS),
      .CNT_BITS  (CNT_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .clr       (req_fire && (req_mode == fpfa_pkg::MODE_CLEAR)),
      .load      (req_fire && (req_mode == fpfa_pkg::MODE_LOAD)),
      .load_size (req_size),
      .rd_addr   (rd_addr),
      .mark_en   (stat.out_load && granted),
      .mark_idx  (pick_idx),
      .rd_size   (cand_size),
      .rd_used   (cand_used),
      .count     (count)
   );

   fpfa_seq #(
      .IDX_BITS (IDX_BITS),
      .CNT_BITS (CNT_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .count    (count),
      .out_busy (out_busy),
      .rd_addr  (rd_addr),
      .cmp_idx  (cmp_idx),
      .ctl      (ctl),
      .stat     (stat)
   );

   fpfa_fit #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_BITS  (IDX_BITS)
   ) u_fit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cmp_idx   (cmp_idx),
      .cand_size (cand_size),
      .cand_used (cand_used),
      .need      (need_ff),
      .policy    (policy_q_ff),
      .granted   (granted),
      .pick_size (pick_size),
      .pick_idx  (pick_idx)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_granted_size = rsp_size_ff;
   assign rsp_block_index  = rsp_idx_ff;

`ifndef ASSERT_OFF
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_ready)
      else $error("ready high right after request word");

   a_grant_in_table: assert property (@(posedge clock) disable iff (reset)
      stat.out_load && granted |-> CNT_BITS'(pick_idx) < count)
      else $error("granted entry beyond loaded count");

   a_grant_fits: assert property (@(posedge clock) disable iff (reset)
      stat.out_load && granted |-> pick_size >= need_ff)
      else $error("granted partition smaller than request");

   a_deny_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_granted_ff |-> rsp_size_ff == '0 && rsp_idx_ff == '0)
      else $error("denied word carries nonzero fields");

   a_policy_bad_denies: assert property (@(posedge clock) disable iff (reset)
      stat.out_load && policy_ff && (policy_q_ff == fpfa_pkg::POLICY_NONE) |-> !granted)
      else $error("grant under unused policy code");
`endif

endmodule
`default_nettype wire

FILE: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCKS     = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = 4;
   localparam int IDLE_LIMIT = 5000;
   localparam int PHASE_WORDS = 105;

   localparam logic [1:0] MODE_NONE   = 2'd3;

   typedef struct packed {
      logic                 granted;
      logic [SIZE_BITS-1:0] gsize;
      logic [IDX_BITS-1:0]  idx;
   } grant_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [SIZE_BITS-1:0] size;
   } word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [1:0]           csr_wr_data = 2'd0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_mode = 2'd0;
   logic [SIZE_BITS-1:0] req_size = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_granted;
   logic [SIZE_BITS-1:0] rsp_granted_size;
   logic [IDX_BITS-1:0]  rsp_block_index;

   word_type  word_q[$];
   grant_type grant_q[$];

   logic [SIZE_BITS-1:0] tbl_size [BLOCKS];
   logic [BLOCKS-1:0]    tbl_used = '0;
   int                   tbl_count = 0;
   logic [1:0]           tbl_policy = fpfa_pkg::POLICY_FIRST;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int stim_count = 0;
   int idle_cycles = 0;

   fixed_partition_fit_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_size         (req_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted      (rsp_granted),
      .rsp_granted_size (rsp_granted_size),
      .rsp_block_index  (rsp_block_index)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic apply_word(input logic [1:0] mode, input logic [SIZE_BITS-1:0] size);
      int pick;
      grant_type g;
      pick = -1;
      g = '0;
      case (mode)
         fpfa_pkg::MODE_CLEAR: begin
            tbl_count = 0;
            tbl_used = '0;
         end
         fpfa_pkg::MODE_LOAD: begin
            if (tbl_count < BLOCKS) begin
               tbl_size[tbl_count] = size;
               tbl_used[tbl_count] = 1'b0;
               tbl_count++;
            end
         end
         fpfa_pkg::MODE_REQ: begin
            for (int k = 0; k < tbl_count; k++) begin
               if (!tbl_used[k]) begin
                  case (tbl_policy)
                     fpfa_pkg::POLICY_FIRST: begin
                        if (pick < 0 && tbl_size[k] >= size) pick = k;
                     end
                     fpfa_pkg::POLICY_BEST: begin
                        if (tbl_size[k] >= size && (pick < 0 || tbl_size[k] < tbl_size[pick]))
                           pick = k;
                     end
                     fpfa_pkg::POLICY_WORST: begin
                        if (pick < 0 || tbl_size[k] > tbl_size[pick]) pick = k;
                     end
                     default: ;
                  endcase
               end
            end
            if (tbl_policy == fpfa_pkg::POLICY_WORST && pick >= 0 && tbl_size[pick] < size)
               pick = -1;
            if (pick >= 0) begin
               tbl_used[pick] = 1'b1;
               g.granted = 1'b1;
               g.gsize = tbl_size[pick];
               g.idx = pick[IDX_BITS-1:0];
            end
            grant_q.push_back(g);
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      logic     take;
      word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && req_ready;
         if (take) apply_word(req_mode, req_size);
         if (!req_valid || take) begin
            if (word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               w = word_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= w.mode;
               req_size <= w.size;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      grant_type exp_g;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (grant_q.size() == 0) begin
               $error("result word with no request pending");
               errors++;
            end else begin
               exp_g = grant_q.pop_front();
               if (rsp_granted !== exp_g.granted) begin
                  $error("granted: expected %0d, actual %0d", exp_g.granted, rsp_granted);
                  errors++;
               end
               if (rsp_granted_size !== exp_g.gsize) begin
                  $error("granted_size: expected %0d, actual %0d", exp_g.gsize,
                         rsp_granted_size);
                  errors++;
               end
               if (rsp_block_index !== exp_g.idx) begin
                  $error("block_index: expected %0d, actual %0d", exp_g.idx, rsp_block_index);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put(input logic [1:0] mode, input logic [SIZE_BITS-1:0] size);
      word_type w;
      w.mode = mode;
      w.size = size;
      word_q.push_back(w);
      if (mode != MODE_NONE) stim_count++;
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_size();
      logic [SIZE_BITS-1:0] s;
      case ($urandom_range(7))
         0: s = SIZE_BITS'($urandom);
         1: s = $urandom_range(1) ? '1 : '0;
         2: s = 16'hFFFF - SIZE_BITS'($urandom_range(0, 40));
         default: s = SIZE_BITS'($urandom_range(0, 40));
      endcase
      return s;
   endfunction

   task automatic add_session();
      int n;
      if ($urandom_range(99) < 85) begin
         if ($urandom_range(3) != 0) put(fpfa_pkg::MODE_CLEAR, SIZE_BITS'($urandom));
         n = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
         repeat (n) put(fpfa_pkg::MODE_LOAD, pick_size());
         repeat ($urandom_range(1, n + 2)) put(fpfa_pkg::MODE_REQ, pick_size());
      end else begin
         repeat ($urandom_range(1, 4)) put(2'($urandom_range(3)), SIZE_BITS'($urandom));
      end
   endtask

   // hold until every word is taken and every result is back
   task automatic drain();
      @(posedge clock);
      while (word_q.size() > 0 || req_valid || grant_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_policy(input logic [1:0] p);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= p;
      tbl_policy = p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int send_pct [4];
      int recv_pct [4];
      logic [1:0] phase_policy [8];
      int target;
      send_pct = '{0, 73, 0, 28};
      recv_pct = '{0, 0, 73, 28};
      phase_policy = '{fpfa_pkg::POLICY_FIRST, fpfa_pkg::POLICY_WORST,
                       fpfa_pkg::POLICY_BEST, fpfa_pkg::POLICY_NONE,
                       fpfa_pkg::POLICY_WORST, fpfa_pkg::POLICY_FIRST,
                       fpfa_pkg::POLICY_BEST, fpfa_pkg::POLICY_WORST};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      put(fpfa_pkg::MODE_REQ, 16'd5);
      put(fpfa_pkg::MODE_LOAD, 16'd0);
      put(fpfa_pkg::MODE_LOAD, 16'hFFFF);
      put(fpfa_pkg::MODE_LOAD, 16'd30);
      put(fpfa_pkg::MODE_LOAD, 16'd30);
      put(MODE_NONE, 16'd7);
      put(fpfa_pkg::MODE_REQ, 16'd0);
      put(fpfa_pkg::MODE_REQ, 16'd20);
      put(fpfa_pkg::MODE_REQ, 16'hFFFF);
      put(fpfa_pkg::MODE_REQ, 16'hFFFF);
      put(fpfa_pkg::MODE_CLEAR, 16'hA5A5);
      put(fpfa_pkg::MODE_REQ, 16'd1);
      drain();
      write_policy(fpfa_pkg::POLICY_BEST);
      put(fpfa_pkg::MODE_LOAD, 16'd40);
      put(fpfa_pkg::MODE_LOAD, 16'd20);
      put(fpfa_pkg::MODE_LOAD, 16'd20);
      put(fpfa_pkg::MODE_REQ, 16'd15);
      put(fpfa_pkg::MODE_REQ, 16'd15);
      put(fpfa_pkg::MODE_REQ, 16'd0);
      drain();
      write_policy(fpfa_pkg::POLICY_WORST);
      put(fpfa_pkg::MODE_CLEAR, 16'd0);
      put(fpfa_pkg::MODE_LOAD, 16'd50);
      put(fpfa_pkg::MODE_LOAD, 16'd50);
      put(fpfa_pkg::MODE_REQ, 16'd60);
      put(fpfa_pkg::MODE_REQ, 16'd10);
      put(fpfa_pkg::MODE_REQ, 16'd0);
      drain();
      write_policy(fpfa_pkg::POLICY_NONE);
      put(fpfa_pkg::MODE_LOAD, 16'd9);
      put(fpfa_pkg::MODE_REQ, 16'd0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct = send_pct[ph / 2];
         recv_stall_pct = recv_pct[ph / 2];
         write_policy(phase_policy[ph]);
         target = stim_count + PHASE_WORDS;
         while (stim_count < target) add_session();
         drain();
      end

      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
